FILE: rtl/core/bitmap_pixel_unpack_to_rgba_core_assert.svh
// Assertion macros used by the checker file of the unpack core.
`ifndef BITMAP_PIXEL_UNPACK_TO_RGBA_CORE_ASSERT_SVH
`define BITMAP_PIXEL_UNPACK_TO_RGBA_CORE_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define BPU_ASSERT_CLK(lbl, clock, resetn, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Clocked assertion on the usual clk and rst_n names.
`define BPU_ASSERT(lbl, prop, msg) \
  `BPU_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

FILE: rtl/core/bpu_pkg.sv
package bpu_pkg;

  typedef enum logic [1:0] {
    FMT_MONO  = 2'd0,
    FMT_PAL4  = 2'd1,
    FMT_PAL8  = 2'd2,
    FMT_BGR24 = 2'd3
  } fmt_t;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 14;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_STRIDE = 3'd3,
    REG_ALPHA  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_abgr;
    logic        last_of_byte;
    logic        end_of_row;
    logic        end_of_image;
  } out_item_t;

  typedef struct packed {
    fmt_t                fmt;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
    logic [7:0]          alpha;
  } cfg_t;

  // One command from the front end: a palette write or a run of pixels of one byte.
  typedef struct packed {
    logic             is_pal;
    fmt_t             fmt;
    logic [23:0]      data;
    logic [7:0]       idx;
    logic [CNT_W-1:0] cnt;
    logic             eor;
    logic             eoi;
  } cmd_t;

endpackage

FILE: rtl/core/bpu_front.sv
module bpu_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpu_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpu_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output bpu_pkg::cmd_t     push_cmd
);

  localparam int DW = bpu_pkg::DIM_W;
  localparam int SW = bpu_pkg::STRIDE_W;
  localparam int CW = bpu_pkg::CNT_W;

  logic [SW-1:0] byte_r, byte_nxt;
  logic [DW-1:0] col_r, col_nxt;
  logic [DW-1:0] row_r, row_nxt;
  logic [15:0]   held_r, held_nxt;
  logic [1:0]    phase_r, phase_nxt;

  logic          acc;
  logic [DW-1:0] eff_w, eff_h, h_one, rem, col_sum;
  logic [CW-1:0] ppb, n;
  logic          in_row, eor, eoi, row_end;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    eff_w = (32'(cfg.width) > MAX_WIDTH) ? DW'(MAX_WIDTH) : cfg.width;
    h_one = (cfg.height == '0) ? DW'(1) : cfg.height;
    eff_h = (32'(h_one) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : h_one;

    in_row = col_r < eff_w;
    rem    = eff_w - col_r;

    unique case (cfg.fmt)
      bpu_pkg::FMT_MONO:  ppb = CW'(8);
      bpu_pkg::FMT_PAL4:  ppb = CW'(2);
      bpu_pkg::FMT_PAL8:  ppb = CW'(1);
      bpu_pkg::FMT_BGR24: ppb = (phase_r == 2'd2) ? CW'(1) : CW'(0);
      default:            ppb = '0;
    endcase

    if (!in_row) begin
      n = '0;
    end else if (rem < DW'(ppb)) begin
      n = rem[CW-1:0];
    end else begin
      n = ppb;
    end

    col_sum = col_r + DW'(n);
    eor     = (n != '0) && (col_sum == eff_w);
    eoi     = eor && ((DW+1)'(row_r) + 1'b1 == (DW+1)'(eff_h));
    row_end = ((SW+1)'(byte_r) + 1'b1) >= (SW+1)'(cfg.stride);

    push = acc && (in_data.op || (n != '0));

    push_cmd.is_pal = in_data.op;
    push_cmd.fmt    = cfg.fmt;
    push_cmd.idx    = in_data.palette_index;
    push_cmd.cnt    = n;
    push_cmd.eor    = eor;
    push_cmd.eoi    = eoi;
    if (in_data.op) begin
      push_cmd.data = {in_data.palette_blue, in_data.palette_green, in_data.palette_red};
    end else if (cfg.fmt == bpu_pkg::FMT_BGR24) begin
      push_cmd.data = {held_r[7:0], held_r[15:8], in_data.data_byte};
    end else begin
      push_cmd.data = {16'h0000, in_data.data_byte};
    end

    byte_nxt  = byte_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    if (acc && !in_data.op) begin
      col_nxt  = col_sum;
      byte_nxt = byte_r + 1'b1;
      if (cfg.fmt == bpu_pkg::FMT_BGR24 && in_row) begin
        unique case (phase_r)
          2'd0: begin
            held_nxt  = {8'h00, in_data.data_byte};
            phase_nxt = 2'd1;
          end
          2'd1: begin
            held_nxt  = {in_data.data_byte, held_r[7:0]};
            phase_nxt = 2'd2;
          end
          default: begin
            held_nxt  = '0;
            phase_nxt = 2'd0;
          end
        endcase
      end
      if (row_end) begin
        byte_nxt  = '0;
        col_nxt   = '0;
        held_nxt  = '0;
        phase_nxt = 2'd0;
        row_nxt   = ((DW+1)'(row_r) + 1'b1 >= (DW+1)'(eff_h)) ? '0 : row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      held_r  <= '0;
      phase_r <= 2'd0;
    end else begin
      byte_r  <= byte_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: rtl/core/bpu_queue.sv
module bpu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bpu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output bpu_pkg::cmd_t head
);

  localparam int DEPTH = bpu_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bpu_pkg::cmd_t q_mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/bpu_back.sv
module bpu_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         alpha,
  input  logic               empty,
  input  bpu_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bpu_pkg::out_item_t out_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = bpu_pkg::CNT_W;

  logic [23:0] pal_mem [PALETTE_DEPTH];

  logic          s1_valid_r;
  bpu_pkg::cmd_t s1_cmd_r;
  logic [2:0]    k_r;

  logic        s2_valid_r, s2_pal_r, s2_lob_r, s2_eor_r, s2_eoi_r;
  logic [23:0] s2_rgb_r, rd_r;

  logic        adv, last, s1_free, pal_wr, use_pal, mono_bit;
  logic [7:0]  idx8;
  logic [23:0] direct_rgb;

  always_comb begin
    adv     = s1_valid_r && (!s2_valid_r || out_ready);
    last    = (CW'(k_r) + 1'b1) == s1_cmd_r.cnt;
    s1_free = !s1_valid_r || (adv && last);
    pop     = !empty && s1_free;
    pal_wr  = pop && head.is_pal && (32'(head.idx) < PALETTE_DEPTH);

    mono_bit = s1_cmd_r.data[3'd7 - k_r];
    unique case (s1_cmd_r.fmt)
      bpu_pkg::FMT_MONO: begin
        idx8       = s1_cmd_r.data[7:0];
        use_pal    = 1'b0;
        direct_rgb = mono_bit ? 24'hFFFFFF : 24'h000000;
      end
      bpu_pkg::FMT_PAL4: begin
        idx8       = k_r[0] ? {4'h0, s1_cmd_r.data[3:0]} : {4'h0, s1_cmd_r.data[7:4]};
        use_pal    = 1'b1;
        direct_rgb = '0;
      end
      bpu_pkg::FMT_PAL8: begin
        // Indices past the end of the palette read as black.
        idx8       = s1_cmd_r.data[7:0];
        use_pal    = 32'(s1_cmd_r.data[7:0]) < PALETTE_DEPTH;
        direct_rgb = '0;
      end
      default: begin
        idx8       = s1_cmd_r.data[7:0];
        use_pal    = 1'b0;
        direct_rgb = s1_cmd_r.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (pop && !head.is_pal) begin
        s1_valid_r <= 1'b1;
      end else if (s1_free) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        s2_valid_r <= 1'b1;
      end else if (out_ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_pal) begin
      s1_cmd_r <= head;
      k_r      <= 3'd0;
    end else if (adv) begin
      k_r <= k_r + 1'b1;
    end
    if (adv) begin
      s2_pal_r <= use_pal;
      s2_rgb_r <= direct_rgb;
      s2_lob_r <= last;
      s2_eor_r <= last && s1_cmd_r.eor;
      s2_eoi_r <= last && s1_cmd_r.eoi;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[head.idx[AW-1:0]] <= head.data;
    end
    if (adv && use_pal) begin
      rd_r <= pal_mem[idx8[AW-1:0]];
    end
  end

  assign out_valid             = s2_valid_r;
  assign out_data.pixel_abgr   = {alpha, s2_pal_r ? rd_r : s2_rgb_r};
  assign out_data.last_of_byte = s2_lob_r;
  assign out_data.end_of_row   = s2_eor_r;
  assign out_data.end_of_image = s2_eoi_r;

endmodule

FILE: rtl/core/bitmap_pixel_unpack_to_rgba_core.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     bpu_pkg::in_item_t  (byte or palette write)
// out      output     out_valid / out_ready   bpu_pkg::out_item_t (one ABGR pixel)
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data (register write)
//
// The back end's issue stage gives one pixel per cycle unless stalled: up to 8 per byte at
// 1 bpp, 2 at 4 bpp and 1 at 8 bpp; at 24 bpp an item is taken every cycle while the queue
// has room, and one pixel leaves per three bytes. A pixel passes the command queue, issue
// stage and output register. Reset is synchronous and active low; it clears position
// state, the command queue and the pipeline, but not the palette, which holds nothing
// until written. A four-entry command queue keeps input flowing on output stalls.

module bitmap_pixel_unpack_to_rgba_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bpu_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bpu_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers. Writes must arrive only while the block is idle; the user
  // is bound to this, as the block does not enforce it and cfg_ready is held high.
  bpu_pkg::cfg_t cfg_r;

  bpu_pkg::cmd_t push_cmd, head;
  logic          push, q_full, pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt    <= bpu_pkg::FMT_BGR24;
      cfg_r.width  <= bpu_pkg::DIM_W'(1);
      cfg_r.height <= bpu_pkg::DIM_W'(1);
      cfg_r.stride <= bpu_pkg::STRIDE_W'(4);
      cfg_r.alpha  <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bpu_pkg::reg_idx_t'(cfg_index))
        bpu_pkg::REG_FORMAT: cfg_r.fmt    <= bpu_pkg::fmt_t'(cfg_data[1:0]);
        bpu_pkg::REG_WIDTH:  cfg_r.width  <= cfg_data[bpu_pkg::DIM_W-1:0];
        bpu_pkg::REG_HEIGHT: cfg_r.height <= cfg_data[bpu_pkg::DIM_W-1:0];
        bpu_pkg::REG_STRIDE: cfg_r.stride <= cfg_data[bpu_pkg::STRIDE_W-1:0];
        bpu_pkg::REG_ALPHA:  cfg_r.alpha  <= cfg_data[7:0];
        default: begin
          // Indices beyond the register list are ignored.
        end
      endcase
    end
  end

  // The front end tracks row and column, counts the pixels each byte yields and
  // queues one command per palette write or per byte that yields pixels.
  bpu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bpu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // The back end applies palette writes in queue order, so a write never
  // overtakes a lookup of an earlier byte, and expands each byte pixel by pixel.
  bpu_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha     (cfg_r.alpha),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/bpu_checker.sv
`include "bitmap_pixel_unpack_to_rgba_core_assert.svh"

module bpu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bpu_pkg::out_item_t out_data
);

  `BPU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled item changed")
  `BPU_ASSERT(a_eoi_eor, out_valid && out_data.end_of_image |-> out_data.end_of_row, "image end off row end")
  `BPU_ASSERT(a_eor_lob, out_valid && out_data.end_of_row |-> out_data.last_of_byte, "row end not last of byte")

endmodule

bind bitmap_pixel_unpack_to_rgba_core bpu_checker u_bpu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/bitmap_pixel_unpack_to_rgba_core_tb.sv
module bitmap_pixel_unpack_to_rgba_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;

  // Which byte of a 24 bpp pixel comes next; they are stored blue first.
  typedef enum logic [1:0] {
    SLOT_BLUE  = 2'd0,
    SLOT_GREEN = 2'd1,
    SLOT_RED   = 2'd2
  } bgr_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  bpu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpu_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bitmap_pixel_unpack_to_rgba_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Items waiting to be offered to the block, and the pixels that the items
  // already accepted are known to produce, oldest first.
  bpu_pkg::in_item_t raw_items[$];
  bpu_pkg::out_item_t pixels_due[$];
  int queued_items = 0;
  int fail_count = 0;

  // Percent chance that the sender holds back an item, or that the receiver
  // stalls, on a given cycle.
  int send_gap_pct = 22;
  int recv_stall_pct = 77;

  // Palette entries that the stimulus has already loaded. Pixel bytes that
  // would read any other entry are preceded by a write of that entry.
  bit pal_loaded [256];

  // Register settings as the block holds them, starting from the reset values.
  bpu_pkg::fmt_t set_fmt = bpu_pkg::FMT_BGR24;
  logic [bpu_pkg::DIM_W-1:0] set_width = 13'd1;
  logic [bpu_pkg::DIM_W-1:0] set_height = 13'd1;
  logic [bpu_pkg::STRIDE_W-1:0] set_stride = 14'd4;
  logic [7:0] set_alpha = 8'd255;

  // Palette copy, position within the stored image and the colors of a 24 bpp pixel so far.
  logic [23:0] pal_rgb [256];
  logic [bpu_pkg::STRIDE_W-1:0] byte_pos = '0;
  logic [bpu_pkg::DIM_W-1:0] pix_col = '0;
  logic [bpu_pkg::DIM_W-1:0] row_cnt = '0;
  logic [15:0] held_bg = '0;
  bgr_slot_t bgr_phase = SLOT_BLUE;

  // Widths above the maximum saturate; a zero height counts as one row.
  function automatic int eff_width();
    return (set_width > MAX_W) ? MAX_W : int'(set_width);
  endfunction

  function automatic int eff_height();
    if (set_height == 0) return 1;
    return (set_height > MAX_H) ? MAX_H : int'(set_height);
  endfunction

  // Builds one pixel at the current column and moves on to the next column.
  function automatic bpu_pkg::out_item_t make_pixel(logic [23:0] rgb, int w, int h);
    bpu_pkg::out_item_t px;
    px.pixel_abgr = {set_alpha, rgb};
    px.last_of_byte = 1'b0;
    px.end_of_row = (pix_col + 1 == w);
    px.end_of_image = px.end_of_row && (row_cnt + 1 == h);
    pix_col = pix_col + 1'b1;
    return px;
  endfunction

  // Works out the pixels that one accepted item produces and advances the
  // position through the stored row.
  task automatic unpack_item(bpu_pkg::in_item_t it);
    bpu_pkg::out_item_t burst[$];
    int w;
    int h;
    int k;
    logic [7:0] b;
    w = eff_width();
    h = eff_height();
    b = it.data_byte;
    if (it.op) begin
      pal_rgb[it.palette_index] = {it.palette_blue, it.palette_green, it.palette_red};
      return;
    end
    case (set_fmt)
      bpu_pkg::FMT_MONO: begin
        for (k = 0; k < 8; k++) begin
          if (pix_col < w) burst.push_back(make_pixel(b[7-k] ? 24'hFFFFFF : 24'h0, w, h));
        end
      end
      bpu_pkg::FMT_PAL4: begin
        if (pix_col < w) burst.push_back(make_pixel(pal_rgb[b[7:4]], w, h));
        if (pix_col < w) burst.push_back(make_pixel(pal_rgb[b[3:0]], w, h));
      end
      bpu_pkg::FMT_PAL8: begin
        if (pix_col < w) burst.push_back(make_pixel(pal_rgb[b], w, h));
      end
      default: begin
        // Bytes that arrive once the width is filled are padding and are not held.
        if (pix_col < w) begin
          case (bgr_phase)
            SLOT_BLUE: begin
              held_bg = {8'h00, b};
              bgr_phase = SLOT_GREEN;
            end
            SLOT_GREEN: begin
              held_bg[15:8] = b;
              bgr_phase = SLOT_RED;
            end
            default: begin
              burst.push_back(make_pixel({held_bg[7:0], held_bg[15:8], b}, w, h));
              held_bg = '0;
              bgr_phase = SLOT_BLUE;
            end
          endcase
        end
      end
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last_of_byte = 1'b1;
    foreach (burst[i]) pixels_due.push_back(burst[i]);

    // A stride of zero behaves as one, which this comparison gives for free.
    if (byte_pos + 1 >= set_stride) begin
      byte_pos = '0;
      pix_col = '0;
      held_bg = '0;
      bgr_phase = SLOT_BLUE;
      row_cnt = (row_cnt + 1 >= h) ? '0 : row_cnt + 1'b1;
    end else begin
      byte_pos = byte_pos + 1'b1;
    end
  endtask

  // The driver offers queued items with random gaps. It only loads a new item
  // once the current one has been taken, so valid and payload hold steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) unpack_item(in_data);
      if (!in_valid || in_ready) begin
        if (raw_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= raw_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  // The monitor takes pixels with random stalls and compares every field
  // with the oldest pixel still due.
  always @(posedge clk) begin
    bpu_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          fail_count++;
          $display("[%0t] unexpected pixel %0h: expected nothing, got a pixel",
                   $time, out_data.pixel_abgr);
        end else begin
          want = pixels_due.pop_front();
          if (out_data.pixel_abgr !== want.pixel_abgr)
            report_mismatch("pixel_abgr", want.pixel_abgr, out_data.pixel_abgr);
          if (out_data.last_of_byte !== want.last_of_byte)
            report_mismatch("last_of_byte", 32'(want.last_of_byte),
                            32'(out_data.last_of_byte));
          if (out_data.end_of_row !== want.end_of_row)
            report_mismatch("end_of_row", 32'(want.end_of_row), 32'(out_data.end_of_row));
          if (out_data.end_of_image !== want.end_of_image)
            report_mismatch("end_of_image", 32'(want.end_of_image),
                            32'(out_data.end_of_image));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_palette(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] bl);
    bpu_pkg::in_item_t it;
    it.op = 1'b1;
    it.data_byte = 8'($urandom);
    it.palette_index = idx;
    it.palette_red = r;
    it.palette_green = g;
    it.palette_blue = bl;
    pal_loaded[idx] = 1'b1;
    raw_items.push_back(it);
    queued_items++;
  endtask

  task automatic make_ready(logic [7:0] idx);
    if (!pal_loaded[idx]) queue_palette(idx, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Queues a pixel data byte. In the palette modes the entries it may read are
  // loaded first, so no read ever touches an entry that was never written.
  task automatic queue_data(logic [7:0] b);
    bpu_pkg::in_item_t it;
    if (set_fmt == bpu_pkg::FMT_PAL4) begin
      make_ready({4'h0, b[7:4]});
      make_ready({4'h0, b[3:0]});
    end else if (set_fmt == bpu_pkg::FMT_PAL8) begin
      make_ready(b);
    end
    it.op = 1'b0;
    it.data_byte = b;
    it.palette_index = 8'($urandom);
    it.palette_red = 8'($urandom);
    it.palette_green = 8'($urandom);
    it.palette_blue = 8'($urandom);
    raw_items.push_back(it);
    queued_items++;
  endtask

  // Random bytes, with the occasional palette rewrite mixed in as noise.
  task automatic queue_random_bytes(int n);
    repeat (n) begin
      if ($urandom_range(15) == 0)
        queue_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      queue_data(8'($urandom));
    end
  endtask

  // Waits until every item has gone in and every pixel has come out, then a
  // few more cycles for pad or palette items that are still in flight.
  task automatic wait_drained();
    while (raw_items.size() != 0 || in_valid || pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bpu_pkg::reg_idx_t idx, int val);
    logic [bpu_pkg::CFG_DATA_W-1:0] v;
    v = bpu_pkg::CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpu_pkg::REG_FORMAT: set_fmt = bpu_pkg::fmt_t'(v[1:0]);
      bpu_pkg::REG_WIDTH:  set_width = v[bpu_pkg::DIM_W-1:0];
      bpu_pkg::REG_HEIGHT: set_height = v[bpu_pkg::DIM_W-1:0];
      bpu_pkg::REG_STRIDE: set_stride = v[bpu_pkg::STRIDE_W-1:0];
      bpu_pkg::REG_ALPHA:  set_alpha = v[7:0];
      default: ;
    endcase
  endtask

  // Rewrites all registers once the block is idle. With realign set, bytes are
  // queued to finish the row and image left open by the previous settings, so
  // that the next items start at the first byte of a fresh image.
  task automatic load_settings(bpu_pkg::fmt_t f, int w, int h, int s, int a, bit realign);
    int sb;
    int hh;
    int n;
    int r;
    wait_drained();
    write_reg(bpu_pkg::REG_FORMAT, f);
    write_reg(bpu_pkg::REG_WIDTH, w);
    write_reg(bpu_pkg::REG_HEIGHT, h);
    write_reg(bpu_pkg::REG_STRIDE, s);
    write_reg(bpu_pkg::REG_ALPHA, a);
    cfg_valid <= 1'b0;
    if (realign) begin
      sb = (set_stride == 0) ? 1 : set_stride;
      hh = eff_height();
      n = 0;
      r = row_cnt;
      if (byte_pos != 0) begin
        n = (byte_pos + 1 >= sb) ? 1 : sb - byte_pos;
        r = (r + 1 >= hh) ? 0 : r + 1;
      end
      if (r != 0) n += (r >= hh) ? sb : (hh - r) * sb;
      queue_random_bytes(n);
    end
  endtask

  function automatic int row_bytes(bpu_pkg::fmt_t f, int w);
    case (f)
      bpu_pkg::FMT_MONO: return (w + 7) / 8;
      bpu_pkg::FMT_PAL4: return (w + 1) / 2;
      bpu_pkg::FMT_PAL8: return w;
      default:           return 3 * w;
    endcase
  endfunction

  initial begin
    bpu_pkg::fmt_t f;
    int w;
    int h;
    int s;
    int a;
    int total;
    int done_items;
    int random_goal;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings are 24 bpp, one pixel, four-byte stride: blue, green and
    // red make one pixel with every flag set, and the fourth byte is padding.
    // Palette writes in between give no pixels.
    queue_palette(8'h00, 8'h00, 8'h00, 8'h00);
    queue_data(8'hFF);
    queue_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_data(8'h00);
    queue_palette(8'h0F, 8'h5A, 8'hA5, 8'h3C);
    queue_data(8'h80);
    queue_data(8'h7F);

    // Mono, nine pixels over two bytes: the second byte yields one white pixel.
    load_settings(bpu_pkg::FMT_MONO, 9, 1, 2, 0, 1'b1);
    queue_data(8'hA5);
    queue_data(8'h80);

    // Zero stride acts as one byte per row, which is short of the width, so
    // neither row ever reaches its end.
    load_settings(bpu_pkg::FMT_MONO, 12, 1, 0, 255, 1'b1);
    queue_data(8'h5A);
    queue_data(8'hFF);

    // 4 bpp with an odd width: the last nibble of the row is dropped.
    load_settings(bpu_pkg::FMT_PAL4, 3, 1, 2, 8'h80, 1'b1);
    queue_data(8'h0F);
    queue_data(8'hF0);

    // 8 bpp with height zero, which counts as one row, plus two pad bytes.
    load_settings(bpu_pkg::FMT_PAL8, 1, 0, 3, 8'h01, 1'b1);
    queue_data(8'hFF);
    queue_data(8'h00);
    queue_data(8'h33);

    // Width zero: bytes go in and no pixels come out.
    load_settings(bpu_pkg::FMT_BGR24, 0, 1, 3, 8'hFE, 1'b1);
    queue_data(8'h12);
    queue_data(8'h34);
    queue_data(8'h56);

    // Random images, mostly complete and well formed with small sizes. Some
    // have short strides or odd sizes and some are cut off part way.
    random_goal = queued_items + 400;
    while (queued_items < random_goal) begin
      done_items = 400 - (random_goal - queued_items);
      if (done_items < 133) begin
        send_gap_pct = 22;
        recv_stall_pct = 77;
      end else if (done_items < 266) begin
        send_gap_pct = 77;
        recv_stall_pct = 22;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      f = bpu_pkg::fmt_t'($urandom_range(3));
      w = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 12);
      h = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 3);
      s = row_bytes(f, w) + $urandom_range(3);
      if ($urandom_range(7) == 0) s = $urandom_range(row_bytes(f, w));
      case ($urandom_range(3))
        0: a = 0;
        1: a = 255;
        default: a = $urandom_range(255);
      endcase
      load_settings(f, w, h, s, a, 1'b1);
      total = ((h == 0) ? 1 : h) * ((s == 0) ? 1 : s);
      if ($urandom_range(5) == 0 && total > 1) total = $urandom_range(1, total - 1);
      queue_random_bytes(total);
    end

    // Largest sizes last, with no idling: a width above the maximum saturates
    // to a full 4096-pixel mono row.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    load_settings(bpu_pkg::FMT_MONO, 8191, 1, 512, 255, 1'b1);
    queue_random_bytes(512);

    // A height above the maximum; only the first two rows are sent.
    load_settings(bpu_pkg::FMT_PAL8, 3, 8191, 3, 8'h7E, 1'b1);
    queue_random_bytes(6);

    // The largest stride, with a short stretch of padding after the pixel bytes of the row.
    load_settings(bpu_pkg::FMT_BGR24, 2, 1, 16383, 8'hC3, 1'b0);
    queue_random_bytes(20);

    // Finish the open row, then one more clean image.
    load_settings(bpu_pkg::FMT_PAL4, 5, 2, 3, 0, 1'b1);
    queue_random_bytes(6);

    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run of this stimulus.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
